// ===== design/mtw_pkg.sv =====
// Package for the multi-task watchdog table: widths, opcodes, entry layout.
// No dependencies.
`timescale 1ns / 1ps
package mtw_pkg;
  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam logic [7:0] MissLimit = 8'd3;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_REG = 3'd1;
  localparam logic [2:0] OP_UNREG = 3'd2;
  localparam logic [2:0] OP_KICK = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam logic [2:0] OP_RESET = 3'd5;
  localparam logic [2:0] OP_SETTMO = 3'd6;
  localparam logic [2:0] OP_ILLEGAL = 3'd7;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_DEF_TMO = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_WARN = 2'd1;
  localparam logic [1:0] ST_CRIT = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] tmo;
    logic [31:0] last_kick;
    logic [7:0]  missed;
    logic [1:0]  status;
    logic        fl_rec;
    logic        fl_crit;
    logic        fl_en;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] task_id;
    logic [31:0] timeout;
    logic        critical;
    logic        has_recovery;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [31:0] task_id_out;
    logic [1:0]  task_state;
    logic [1:0]  overall_state;
    logic [31:0] timeout_total;
    logic [31:0] recovery_total;
    logic        last;
  } out_item_t;
endpackage

// ===== design/mtw_stream_if.sv =====
// Valid/ready stream channel interface carrying one packed payload.
// Depends on nothing; the payload type comes from mtw_pkg at the use site.
`timescale 1ns / 1ps
interface mtw_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/mtw_ram.sv =====
// Generic simple dual-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mtw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/multi_task_watchdog_table_unit.sv =====
// The watchdog table sits in one entry RAM; a sequencer walks it one entry at a
// time for ID searches, scans, compaction and reset-all. Every visited entry passes
// a read (or, for removal, shift) state and an evaluate state. Each recovery
// request holds the walk in a wait state until it is transferred, and the next
// item is taken only after the final result is transferred.
// Depends on mtw_pkg, mtw_stream_if and mtw_ram.
`timescale 1ns / 1ps
module multi_task_watchdog_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  mtw_stream_if.sink   in_if,
  mtw_stream_if.source out_if
);
  import mtw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]      state_q, state_d;
  in_item_t        item_q;
  logic [CntW-1:0] idx_q, idx_d, count_q, count_d;
  logic [31:0]     now_q, now_d, lastchk_q, lastchk_d;
  logic [1:0]      ovr_q, ovr_d;
  logic [31:0]     tmo_tot_q, tmo_tot_d, rec_tot_q, rec_tot_d;
  logic            en_q;
  logic [31:0]     intv_q, deftmo_q;
  logic            ok_q, ok_d;
  logic [1:0]      tst_q, tst_d;
  logic            found_q, found_d;
  out_item_t       out_q, out_d;
  logic            ov_q, ov_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rd;
  logic [EntryW-1:0] rdata_raw;

  mtw_ram #(.Width(EntryW), .Depth(MaxTasks)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rd = entry_t'(rdata_raw);

  logic [31:0] elapsed;
  logic [35:0] e10, t7;
  logic [7:0]  miss_inc;
  logic [CntW-1:0] idx_p1;
  logic        in_range;
  entry_t      upd;

  assign elapsed = now_q - rd.last_kick;
  assign e10 = {1'b0, elapsed, 3'b0} + {3'b0, elapsed, 1'b0};
  assign t7 = {1'b0, rd.tmo, 3'b0} - {4'b0, rd.tmo};
  assign miss_inc = (rd.missed == 8'hff) ? rd.missed : rd.missed + 8'd1;
  assign idx_p1 = idx_q + 1'b1;
  assign in_range = idx_q < count_q;
  assign in_if.ready = (state_q == S_IDLE) && !ov_q;
  assign out_if.valid = ov_q;
  assign out_if.data = out_q;

  always_comb begin
    state_d = state_q; idx_d = idx_q; count_d = count_q; now_d = now_q;
    lastchk_d = lastchk_q; ovr_d = ovr_q; tmo_tot_d = tmo_tot_q;
    rec_tot_d = rec_tot_q; ok_d = ok_q; tst_d = tst_q; found_d = found_q;
    out_d = out_q; ov_d = ov_q && !out_if.ready;
    we = 1'b0; waddr = idx_q[IdxW-1:0]; wdata = rd; raddr = idx_q[IdxW-1:0];
    upd = rd;
    if (cfg_we_i && cfg_index_i == CFG_ENABLE && cfg_data_i[0]) begin
      lastchk_d = now_q;
    end
    case (state_q)
      S_IDLE: begin
        idx_d = '0; ok_d = 1'b0; tst_d = ST_OK; found_d = 1'b0;
        raddr = '0;
        if (in_if.valid && in_if.ready) begin
          state_d = S_READ;
          if (in_if.data.opcode == OP_TICK) begin
            now_d = now_q + 32'd1;
            ok_d = 1'b1;
            if (!en_q || (now_d - lastchk_q) < intv_q) begin
              state_d = S_DONE;
            end else begin
              lastchk_d = now_d; ovr_d = ST_OK;
            end
          end else if (in_if.data.opcode == OP_RESET) begin
            ovr_d = ST_OK; tmo_tot_d = '0; rec_tot_d = '0; ok_d = 1'b1;
          end else if (in_if.data.opcode > OP_SETTMO) begin
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        // RAM read of entry idx_q was issued; data valid next cycle.
        state_d = in_range ? S_EVAL : S_DONE;
        if (!in_range && item_q.opcode == OP_REG && count_q < CntW'(MaxTasks)) begin
          we = 1'b1; waddr = count_q[IdxW-1:0];
          wdata.id = item_q.task_id;
          wdata.tmo = (item_q.timeout != 0) ? item_q.timeout : deftmo_q;
          wdata.last_kick = now_q; wdata.missed = '0; wdata.status = ST_OK;
          wdata.fl_en = 1'b1; wdata.fl_crit = item_q.critical;
          wdata.fl_rec = item_q.has_recovery;
          count_d = count_q + 1'b1; ok_d = 1'b1;
        end
      end
      S_EVAL: begin
        raddr = idx_p1[IdxW-1:0];
        idx_d = idx_p1;
        state_d = S_READ;
        case (item_q.opcode)
          OP_TICK: begin
            if (rd.fl_en) begin
              we = 1'b1;
              if (elapsed > rd.tmo) begin
                upd.missed = miss_inc;
                upd.status = (miss_inc >= MissLimit) ? ST_CRIT : ST_TIMEOUT;
                tmo_tot_d = tmo_tot_q + 32'd1;
                if (rd.fl_crit) ovr_d = ST_CRIT;
                else if (ovr_q == ST_OK) ovr_d = ST_WARN;
                if (rd.fl_crit && rd.fl_rec) begin
                  rec_tot_d = rec_tot_q + 32'd1;
                  out_d.kind = 1'b1; out_d.ok = 1'b1; out_d.task_id_out = rd.id;
                  out_d.task_state = upd.status; out_d.overall_state = ovr_d;
                  out_d.timeout_total = tmo_tot_d; out_d.recovery_total = rec_tot_d;
                  out_d.last = 1'b0; ov_d = 1'b1;
                  state_d = S_WAIT;
                end
              end else if (e10 > t7) begin
                if (rd.status == ST_OK) upd.status = ST_WARN;
              end else begin
                upd.status = ST_OK;
              end
              wdata = upd;
            end
          end
          OP_RESET: begin
            we = 1'b1; upd.missed = '0; upd.status = ST_OK; upd.last_kick = now_q;
            wdata = upd;
          end
          OP_UNREG: begin
            if (found_q) begin
              we = 1'b1; waddr = idx_q[IdxW-1:0] - 1'b1; wdata = rd;
            end else if (rd.id == item_q.task_id) begin
              found_d = 1'b1; ok_d = 1'b1;
            end
            state_d = S_SHIFT;
          end
          default: begin
            if (rd.id == item_q.task_id) begin
              state_d = S_DONE;
              ok_d = 1'b1;
              if (item_q.opcode == OP_REG) begin
                ok_d = 1'b0;
              end else if (item_q.opcode == OP_QUERY) begin
                tst_d = rd.status;
              end else if (item_q.opcode == OP_KICK) begin
                we = 1'b1; upd.last_kick = now_q; upd.missed = '0;
                if (rd.status == ST_WARN || rd.status == ST_TIMEOUT) upd.status = ST_OK;
                wdata = upd;
              end else if (item_q.opcode == OP_SETTMO) begin
                we = 1'b1; upd.tmo = item_q.timeout; wdata = upd;
              end
            end
          end
        endcase
      end
      S_SHIFT: begin
        // Read of the next entry is in flight; end of table closes removal.
        state_d = in_range ? S_EVAL : S_DONE;
        if (!in_range && found_q) count_d = count_q - 1'b1;
      end
      S_WAIT: begin
        raddr = idx_q[IdxW-1:0];
        if (!ov_q) state_d = S_READ;
      end
      S_DONE: begin
        if (!ov_q) begin
          out_d.kind = 1'b0; out_d.ok = ok_q;
          out_d.task_id_out = (item_q.opcode == OP_TICK || item_q.opcode == OP_RESET
                               || item_q.opcode > OP_SETTMO) ? 32'd0 : item_q.task_id;
          out_d.task_state = tst_q; out_d.overall_state = ovr_q;
          out_d.timeout_total = tmo_tot_q; out_d.recovery_total = rec_tot_q;
          out_d.last = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; idx_q <= '0; count_q <= '0; now_q <= '0;
      lastchk_q <= '0; ovr_q <= ST_OK; tmo_tot_q <= '0; rec_tot_q <= '0;
      en_q <= 1'b1; intv_q <= 32'd100; deftmo_q <= 32'd1000;
      ok_q <= 1'b0; tst_q <= ST_OK; found_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; count_q <= count_d; now_q <= now_d;
      lastchk_q <= lastchk_d; ovr_q <= ovr_d; tmo_tot_q <= tmo_tot_d;
      rec_tot_q <= rec_tot_d; ok_q <= ok_d; tst_q <= tst_d; found_q <= found_d;
      ov_q <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLE: en_q <= cfg_data_i[0];
          CFG_INTERVAL: intv_q <= cfg_data_i;
          CFG_DEF_TMO: deftmo_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxTasks)) else $error("entry count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == S_IDLE) else $error("accept while busy");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.last) |-> state_q == S_IDLE)
    else $error("final result before item done");
`endif
endmodule

// ===== tb/multi_task_watchdog_table_unit_tb.sv =====
// Self-checking testbench for the multi-task watchdog table unit.
// Depends on mtw_pkg, mtw_stream_if and the unit itself; predicts every result.
`timescale 1ns / 1ps
module multi_task_watchdog_table_unit_tb;
  import mtw_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_ENABLE;
  logic [31:0] cfg_data_i = '0;

  mtw_stream_if #(.payload_t(in_item_t)) in_if ();
  mtw_stream_if #(.payload_t(out_item_t)) out_if ();

  multi_task_watchdog_table_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_if),
    .out_if(out_if)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Watchdog model state.
  logic [31:0] tbl_id [MaxTasks];
  logic [31:0] tbl_tmo [MaxTasks];
  logic [31:0] tbl_kick [MaxTasks];
  logic [7:0] tbl_miss [MaxTasks];
  logic [1:0] tbl_state [MaxTasks];
  logic tbl_en [MaxTasks];
  logic tbl_crit [MaxTasks];
  logic tbl_rec [MaxTasks];
  int unsigned n_tasks = 0;
  logic [31:0] clock_ms = '0;
  logic [31:0] last_scan = '0;
  logic [1:0] health = ST_OK;
  logic [31:0] n_timeouts = '0;
  logic [31:0] n_recoveries = '0;
  logic wd_enable = 1'b1;
  logic [31:0] scan_period = 32'd100;
  logic [31:0] dflt_tmo = 32'd1000;

  out_item_t pending_results[$];
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  longint unsigned cycle_cnt = 0;
  logic [31:0] id_pool [8];

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic int find_task(input logic [31:0] id);
    for (int i = 0; i < n_tasks; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic out_item_t mk_result(input logic kind, input logic ok,
                                          input logic [31:0] id, input logic [1:0] st,
                                          input logic lst);
    out_item_t r;
    r.kind = kind;
    r.ok = ok;
    r.task_id_out = id;
    r.task_state = st;
    r.overall_state = health;
    r.timeout_total = n_timeouts;
    r.recovery_total = n_recoveries;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_watchdog(input in_item_t it);
    logic ok;
    logic [31:0] id_out;
    logic [1:0] st;
    logic [31:0] elapsed;
    int f;
    ok = 1'b0;
    id_out = it.task_id;
    st = ST_OK;
    case (it.opcode)
      OP_TICK: begin
        ok = 1'b1;
        id_out = '0;
        clock_ms = clock_ms + 32'd1;
        if (wd_enable && (clock_ms - last_scan) >= scan_period) begin
          last_scan = clock_ms;
          health = ST_OK;
          for (int i = 0; i < n_tasks; i++) begin
            if (!tbl_en[i]) continue;
            elapsed = clock_ms - tbl_kick[i];
            if (elapsed > tbl_tmo[i]) begin
              if (tbl_miss[i] != 8'd255) tbl_miss[i]++;
              tbl_state[i] = ST_TIMEOUT;
              n_timeouts++;
              if (tbl_crit[i]) health = ST_CRIT;
              else if (health == ST_OK) health = ST_WARN;
              if (tbl_miss[i] >= MissLimit) tbl_state[i] = ST_CRIT;
              if (tbl_crit[i] && tbl_rec[i]) begin
                n_recoveries++;
                pending_results.push_back(mk_result(1'b1, 1'b1, tbl_id[i], tbl_state[i], 1'b0));
              end
            end else if ({4'd0, elapsed} * 36'd10 > {4'd0, tbl_tmo[i]} * 36'd7) begin
              if (tbl_state[i] == ST_OK) tbl_state[i] = ST_WARN;
            end else begin
              tbl_state[i] = ST_OK;
            end
          end
        end
      end
      OP_REG: begin
        if (n_tasks < MaxTasks && find_task(it.task_id) < 0) begin
          tbl_id[n_tasks] = it.task_id;
          tbl_tmo[n_tasks] = (it.timeout != 0) ? it.timeout : dflt_tmo;
          tbl_kick[n_tasks] = clock_ms;
          tbl_miss[n_tasks] = '0;
          tbl_state[n_tasks] = ST_OK;
          tbl_en[n_tasks] = 1'b1;
          tbl_crit[n_tasks] = it.critical;
          tbl_rec[n_tasks] = it.has_recovery;
          n_tasks++;
          ok = 1'b1;
        end
      end
      OP_UNREG: begin
        f = find_task(it.task_id);
        if (f >= 0) begin
          for (int i = f; i + 1 < n_tasks; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_tmo[i] = tbl_tmo[i+1];
            tbl_kick[i] = tbl_kick[i+1];
            tbl_miss[i] = tbl_miss[i+1];
            tbl_state[i] = tbl_state[i+1];
            tbl_en[i] = tbl_en[i+1];
            tbl_crit[i] = tbl_crit[i+1];
            tbl_rec[i] = tbl_rec[i+1];
          end
          n_tasks--;
          ok = 1'b1;
        end
      end
      OP_KICK: begin
        f = find_task(it.task_id);
        if (f >= 0) begin
          tbl_kick[f] = clock_ms;
          tbl_miss[f] = '0;
          if (tbl_state[f] == ST_WARN || tbl_state[f] == ST_TIMEOUT) tbl_state[f] = ST_OK;
          ok = 1'b1;
        end
      end
      OP_QUERY: begin
        f = find_task(it.task_id);
        if (f >= 0) begin
          ok = 1'b1;
          st = tbl_state[f];
        end
      end
      OP_RESET: begin
        for (int i = 0; i < n_tasks; i++) begin
          tbl_miss[i] = '0;
          tbl_state[i] = ST_OK;
          tbl_kick[i] = clock_ms;
        end
        health = ST_OK;
        n_timeouts = '0;
        n_recoveries = '0;
        ok = 1'b1;
        id_out = '0;
      end
      OP_SETTMO: begin
        f = find_task(it.task_id);
        if (f >= 0) begin
          tbl_tmo[f] = it.timeout;
          ok = 1'b1;
        end
      end
      default: id_out = '0;
    endcase
    pending_results.push_back(mk_result(1'b0, ok, id_out, st, 1'b1));
  endtask

  task automatic send_item(input logic [2:0] op, input logic [31:0] id,
                           input logic [31:0] tmo, input logic crit, input logic rec);
    in_item_t it;
    it.opcode = op;
    it.task_id = id;
    it.timeout = tmo;
    it.critical = crit;
    it.has_recovery = rec;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_watchdog(it);
    // The unit is busy right after a transfer, so this cycle costs nothing.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    // Extra idle cycles before the next phase.
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    wait_drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLE: begin
        wd_enable = val[0];
        if (val[0]) last_scan = clock_ms;
      end
      CFG_INTERVAL: scan_period = val;
      default: dflt_tmo = val;
    endcase
  endtask

  // Result checker with random back-pressure.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_r = pending_results.pop_front();
          if (out_if.data.kind !== exp_r.kind) report_mismatch("kind differs");
          if (out_if.data.ok !== exp_r.ok) report_mismatch("ok differs");
          if (out_if.data.task_id_out !== exp_r.task_id_out) report_mismatch("task id differs");
          if (out_if.data.task_state !== exp_r.task_state) report_mismatch("task state differs");
          if (out_if.data.overall_state !== exp_r.overall_state)
            report_mismatch("overall state differs");
          if (out_if.data.timeout_total !== exp_r.timeout_total)
            report_mismatch("timeout total differs");
          if (out_if.data.recovery_total !== exp_r.recovery_total)
            report_mismatch("recovery total differs");
          if (out_if.data.last !== exp_r.last) report_mismatch("last flag differs");
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_item(OP_TICK, $urandom, $urandom, 1'($urandom), 1'($urandom));
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, 32'h0, 32'd0, 1'b0, 1'b0);
    send_item(OP_REG, 32'hFFFF_FFFF, 32'd20, 1'b1, 1'b1);
    send_item(OP_REG, 32'hFFFF_FFFF, 32'd5, 1'b0, 1'b0);
    send_item(OP_REG, 32'h0, 32'd0, 1'b0, 1'b1);
    send_item(OP_REG, 32'h5555_AAAA, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(OP_REG, 32'hAAAA_5555, 32'd10, 1'b0, 1'b0);
    send_item(OP_SETTMO, 32'hAAAA_5555, 32'd0, 1'b0, 1'b0);
    send_item(OP_SETTMO, 32'h1234, 32'd7, 1'b0, 1'b0);
    send_item(OP_ILLEGAL, 32'h77, 32'd1, 1'b1, 1'b1);
    send_ticks(4);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    send_item(OP_KICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    send_item(OP_KICK, 32'h4321, 32'd0, 1'b0, 1'b0);
    send_item(OP_UNREG, 32'h0, 32'd0, 1'b0, 1'b0);
    send_item(OP_UNREG, 32'h0, 32'd0, 1'b0, 1'b0);
    send_item(OP_RESET, 32'h99, 32'd0, 1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_INTERVAL, 32'd0);
    write_cfg(CFG_DEF_TMO, 32'd0);
    send_item(OP_REG, 32'h10, 32'd0, 1'b1, 1'b1);
    send_ticks(6);
    for (int i = 0; i < 17; i++) send_item(OP_REG, 32'h100 + i, i, i[0], i[1]);
    send_ticks(5);
    write_cfg(CFG_DEF_TMO, 32'hFFFF_FFFF);
    write_cfg(CFG_ENABLE, 32'd0);
    send_ticks(3);
    write_cfg(CFG_INTERVAL, 32'hFFFF_FFFF);
    write_cfg(CFG_ENABLE, 32'd1);
    send_ticks(3);
    send_item(OP_RESET, 32'd0, 32'd0, 1'b0, 1'b0);
    for (int i = 0; i < 17; i++) send_item(OP_UNREG, 32'h100 + i, 32'd0, 1'b0, 1'b0);
    send_item(OP_UNREG, 32'h10, 32'd0, 1'b0, 1'b0);
    wait_drain();
    write_cfg(CFG_INTERVAL, 32'd2);
    write_cfg(CFG_DEF_TMO, 32'd6);
    write_cfg(CFG_ENABLE, 32'd1);
  endtask

  task automatic test_random(input int n);
    int unsigned r;
    logic [31:0] id;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
      if (r < 40) send_item(OP_TICK, $urandom, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 55) send_item(OP_REG, id,
                                 ($urandom_range(7) == 0) ? $urandom : $urandom_range(12),
                                 1'($urandom), 1'($urandom));
      else if (r < 63) send_item(OP_UNREG, id, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 75) send_item(OP_KICK, id, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 88) send_item(OP_QUERY, id, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 90) send_item(OP_RESET, id, $urandom, 1'($urandom), 1'($urandom));
      else if (r < 97) send_item(OP_SETTMO, id, $urandom_range(12), 1'($urandom),
                                 1'($urandom));
      else send_item(OP_ILLEGAL, id, $urandom, 1'($urandom), 1'($urandom));
    end
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 17;
    recv_idle_pct = 74;
    test_directed();
    test_config_extremes();
    test_random(125);
    send_idle_pct = 74;
    recv_idle_pct = 17;
    write_cfg(CFG_INTERVAL, 32'd1);
    write_cfg(CFG_DEF_TMO, 32'd3);
    test_random(125);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_INTERVAL, 32'd3);
    test_random(125);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
